[design/segment_triangle_intersect_assert.svh]
`ifndef SEGMENT_TRIANGLE_INTERSECT_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define STI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define STI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/sti_pkg.sv]
package sti_pkg;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int ADDR_W = 3;
	localparam int THR_W = 20;
	localparam logic [THR_W-1:0] THR_RESET = 20'd1;
	localparam logic [0:0] REG_PARALLEL_THRESHOLD = 1'b0;
endpackage

[design/segment_triangle_intersect.sv]
// segment / triangle intersection with barycentric weights
// input channel: in_valid / in_stall carry seg_start, seg_end and the
// triangle vert_a, vert_b, vert_c, each three packed signed coordinates
// (x at bit 0, y at COORD_BITS, z at 2*COORD_BITS)
// output channel: out_valid / out_stall carry hit and bary_s, bary_t,
// bary_w in unsigned Q1.FRAC_BITS; all weights are zero on a miss
// a transfer happens on a rising edge with valid high and stall low
// stages from input transfer to result valid: seven arithmetic
// stages, one stage per quotient bit of the two shared-denominator
// dividers, and an output register
// throughput: one item per cycle unless stalled; every stage has its
// own valid bit and loads whenever it is empty or the stage after it
// moves; bubbles collapse and items keep entering while a result waits
// receiver stall: the last stage holds its result, stages behind it
// fill up, and in_stall rises only when every stage holds an item
// reset: all valid bits clear, parallel_threshold returns to 1
// config: parallel_threshold at byte address 0 over the apb port
module segment_triangle_intersect #(
	parameter int COORD_BITS = sti_pkg::COORD_BITS,
	parameter int FRAC_BITS = sti_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sti_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [3*COORD_BITS-1:0]       seg_start,
	input  logic [3*COORD_BITS-1:0]       seg_end,
	input  logic [3*COORD_BITS-1:0]       vert_a,
	input  logic [3*COORD_BITS-1:0]       vert_b,
	input  logic [3*COORD_BITS-1:0]       vert_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [FRAC_BITS:0]            bary_s,
	output logic [FRAC_BITS:0]            bary_t,
	output logic [FRAC_BITS:0]            bary_w
);
	localparam int C = COORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int DW = C + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam int QW = XW + DW;
	localparam int SW = QW + 2;
	localparam int UW = SW - 1;
	localparam int FRONT = 7;
	localparam int NS = FRONT + F + 1;
	localparam int TW = sti_pkg::THR_W;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	logic [TW-1:0] thr_q;
	logic [NS:1]   vld;
	logic [NS:1]   en;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[sti_pkg::ADDR_W-1:2] == sti_pkg::REG_PARALLEL_THRESHOLD) ?
		32'(thr_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sti_pkg::THR_RESET;
		end else if (psel && penable && pwrite &&
			paddr[sti_pkg::ADDR_W-1:2] == sti_pkg::REG_PARALLEL_THRESHOLD) begin
			thr_q <= pwdata[TW-1:0];
		end
	end

	// stage enables and valid bits
	always_comb begin
		en[NS] = !vld[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign in_stall = !en[1];
	assign out_valid = vld[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[1]) vld[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) vld[k] <= vld[k-1];
			end
		end
	end

	// unpack
	logic signed [C-1:0] cs [3], ce [3], ca [3], cb [3], cc [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cs[k] = $signed(seg_start[k*C +: C]);
			ce[k] = $signed(seg_end[k*C +: C]);
			ca[k] = $signed(vert_a[k*C +: C]);
			cb[k] = $signed(vert_b[k*C +: C]);
			cc[k] = $signed(vert_c[k*C +: C]);
		end
	end

	// s1: edge and direction vectors
	logic signed [DW-1:0] d_s1 [3], u_s1 [3], v_s1 [3], w0_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]  <= DW'(ce[k]) - DW'(cs[k]);
				u_s1[k]  <= DW'(cb[k]) - DW'(ca[k]);
				v_s1[k]  <= DW'(cc[k]) - DW'(ca[k]);
				w0_s1[k] <= DW'(cs[k]) - DW'(ca[k]);
			end
		end
	end

	// s2: cross product terms
	logic signed [PW-1:0] na_s2 [3], nb_s2 [3], va_s2 [3], vb_s2 [3], ua_s2 [3], ub_s2 [3];
	logic signed [DW-1:0] d_s2 [3], w0_s2 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 3; k++) begin
				na_s2[k] <= PW'(u_s1[NXT[k]]) * PW'(v_s1[PRV[k]]);
				nb_s2[k] <= PW'(u_s1[PRV[k]]) * PW'(v_s1[NXT[k]]);
				va_s2[k] <= PW'(v_s1[NXT[k]]) * PW'(d_s1[PRV[k]]);
				vb_s2[k] <= PW'(v_s1[PRV[k]]) * PW'(d_s1[NXT[k]]);
				ua_s2[k] <= PW'(u_s1[NXT[k]]) * PW'(w0_s1[PRV[k]]);
				ub_s2[k] <= PW'(u_s1[PRV[k]]) * PW'(w0_s1[NXT[k]]);
				d_s2[k]  <= d_s1[k];
				w0_s2[k] <= w0_s1[k];
			end
		end
	end

	// s3: normal, v x d, u x w0
	logic signed [XW-1:0] n_s3 [3], vd_s3 [3], uw_s3 [3];
	logic signed [DW-1:0] d_s3 [3], w0_s3 [3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int k = 0; k < 3; k++) begin
				n_s3[k]  <= XW'(na_s2[k]) - XW'(nb_s2[k]);
				vd_s3[k] <= XW'(va_s2[k]) - XW'(vb_s2[k]);
				uw_s3[k] <= XW'(ua_s2[k]) - XW'(ub_s2[k]);
				d_s3[k]  <= d_s2[k];
				w0_s3[k] <= w0_s2[k];
			end
		end
	end

	// s4: dot product terms, degenerate flag
	logic signed [QW-1:0] pnd_s4 [3], pnw_s4 [3], psn_s4 [3], ptn_s4 [3];
	logic                 nz_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int k = 0; k < 3; k++) begin
				pnd_s4[k] <= QW'(n_s3[k]) * QW'(d_s3[k]);
				pnw_s4[k] <= QW'(n_s3[k]) * QW'(w0_s3[k]);
				psn_s4[k] <= QW'(w0_s3[k]) * QW'(vd_s3[k]);
				ptn_s4[k] <= QW'(d_s3[k]) * QW'(uw_s3[k]);
			end
			nz_s4 <= (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
		end
	end

	// s5: sums
	logic signed [SW-1:0] den_s5, num_s5, sn_s5, tn_s5;
	logic                 nz_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			den_s5 <= SW'(pnd_s4[0]) + SW'(pnd_s4[1]) + SW'(pnd_s4[2]);
			num_s5 <= -(SW'(pnw_s4[0]) + SW'(pnw_s4[1]) + SW'(pnw_s4[2]));
			sn_s5  <= SW'(psn_s4[0]) + SW'(psn_s4[1]) + SW'(psn_s4[2]);
			tn_s5  <= SW'(ptn_s4[0]) + SW'(ptn_s4[1]) + SW'(ptn_s4[2]);
			nz_s5  <= nz_s4;
		end
	end

	// s6: make the denominator positive
	logic signed [SW-1:0] den_s6, num_s6, sn_s6, tn_s6;
	logic                 nz_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			if (den_s5 < 0) begin
				den_s6 <= -den_s5;
				num_s6 <= -num_s5;
				sn_s6  <= -sn_s5;
				tn_s6  <= -tn_s5;
			end else begin
				den_s6 <= den_s5;
				num_s6 <= num_s5;
				sn_s6  <= sn_s5;
				tn_s6  <= tn_s5;
			end
			nz_s6 <= nz_s5;
		end
	end

	// s7: hit tests, divider setup (index 0 of the divider arrays)
	logic [UW-1:0] den_d [F+1];
	logic [UW-1:0] xs_d [F+1], xt_d [F+1];
	logic [F-1:0]  qs_d [F+1], qt_d [F+1];
	logic          hit_d [F+1], sat_d [F+1], satt_d [F+1];
	logic signed [SW-1:0] thr_ext;
	logic signed [SW:0]   st_sum;
	logic                 miss;

	always_comb begin
		thr_ext = $signed({{(SW-TW){1'b0}}, thr_q});
		st_sum = (SW+1)'(sn_s6) + (SW+1)'(tn_s6);
		miss = nz_s6 || (den_s6 == '0) || (den_s6 < thr_ext) || (num_s6 < 0) ||
			(den_s6 < num_s6) || (sn_s6 < 0) || (tn_s6 < 0) ||
			((SW+1)'(den_s6) < st_sum);
	end

	always_ff @(posedge clk) begin
		if (en[FRONT]) begin
			den_d[0]  <= den_s6[UW-1:0];
			xs_d[0]   <= sn_s6[UW-1:0];
			xt_d[0]   <= tn_s6[UW-1:0];
			qs_d[0]   <= '0;
			qt_d[0]   <= '0;
			hit_d[0]  <= !miss;
			sat_d[0]  <= !(sn_s6 < den_s6);
			satt_d[0] <= !(tn_s6 < den_s6);
		end
	end

	// restoring dividers, one quotient bit per stage
	logic [UW:0] xs2 [F], xt2 [F];
	logic        ges [F], get [F];

	always_comb begin
		for (int j = 0; j < F; j++) begin
			xs2[j] = {xs_d[j], 1'b0};
			xt2[j] = {xt_d[j], 1'b0};
			ges[j] = xs2[j] >= {1'b0, den_d[j]};
			get[j] = xt2[j] >= {1'b0, den_d[j]};
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < F; j++) begin
			if (en[FRONT+1+j]) begin
				den_d[j+1]  <= den_d[j];
				xs_d[j+1]   <= ges[j] ? UW'(xs2[j] - {1'b0, den_d[j]}) : xs2[j][UW-1:0];
				xt_d[j+1]   <= get[j] ? UW'(xt2[j] - {1'b0, den_d[j]}) : xt2[j][UW-1:0];
				qs_d[j+1]   <= {qs_d[j][F-2:0], ges[j]};
				qt_d[j+1]   <= {qt_d[j][F-2:0], get[j]};
				hit_d[j+1]  <= hit_d[j];
				sat_d[j+1]  <= sat_d[j];
				satt_d[j+1] <= satt_d[j];
			end
		end
	end

	// output register
	logic [F:0] s_fin, t_fin;
	logic       hit_q;
	logic [F:0] s_q, t_q, w_q;

	always_comb begin
		s_fin = sat_d[F] ? {1'b1, {F{1'b0}}} : {1'b0, qs_d[F]};
		t_fin = satt_d[F] ? {1'b1, {F{1'b0}}} : (sat_d[F] ? '0 : {1'b0, qt_d[F]});
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			hit_q <= hit_d[F];
			if (hit_d[F]) begin
				s_q <= s_fin;
				t_q <= t_fin;
				w_q <= {1'b1, {F{1'b0}}} - s_fin - t_fin;
			end else begin
				s_q <= '0;
				t_q <= '0;
				w_q <= '0;
			end
		end
	end

	assign hit = hit_q;
	assign bary_s = s_q;
	assign bary_t = t_q;
	assign bary_w = w_q;
endmodule

[design/sti_checker.sv]
`include "segment_triangle_intersect_assert.svh"

module sti_checker #(
	parameter int FRAC_BITS = sti_pkg::FRAC_BITS
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic [FRAC_BITS:0] bary_s,
	input logic [FRAC_BITS:0] bary_t,
	input logic [FRAC_BITS:0] bary_w
);
	localparam logic [FRAC_BITS+2:0] ONE = (FRAC_BITS+3)'(1) << FRAC_BITS;

	logic [FRAC_BITS+2:0] wsum;

	assign wsum = (FRAC_BITS+3)'(bary_s) + (FRAC_BITS+3)'(bary_t) + (FRAC_BITS+3)'(bary_w);

	`STI_ASSERT_IMP(a_miss_zero, out_valid && !hit, bary_s == '0 && bary_t == '0 && bary_w == '0, "miss with nonzero weights")
	`STI_ASSERT_IMP(a_hit_sum, out_valid && hit, wsum == ONE, "hit weights do not sum to one")
	`STI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(bary_s), "stalled result changed")
endmodule

bind segment_triangle_intersect sti_checker #(.FRAC_BITS(FRAC_BITS)) u_sti_checker (.*);

[tb/segment_triangle_intersect_tb.sv]
`timescale 1ns / 1ps

module segment_triangle_intersect_tb;
	localparam int CW = sti_pkg::COORD_BITS;
	localparam int PW = 3 * sti_pkg::COORD_BITS;
	localparam int OW = sti_pkg::FRAC_BITS + 1;
	localparam int LATENCY = 8 + sti_pkg::FRAC_BITS;
	localparam int RANDOM_ITEMS = 550;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [PW-1:0] p0;
		logic [PW-1:0] p1;
		logic [PW-1:0] va;
		logic [PW-1:0] vb;
		logic [PW-1:0] vc;
	} geom_t;

	typedef struct packed {
		logic hit;
		logic [OW-1:0] s;
		logic [OW-1:0] t;
		logic [OW-1:0] w;
	} bary_res_t;

	typedef struct {
		geom_t g;
		logic known;
		bary_res_t res;
	} vec_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [sti_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [PW-1:0] seg_start = '0, seg_end = '0, vert_a = '0, vert_b = '0, vert_c = '0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	logic [OW-1:0] bary_s, bary_t, bary_w;

	segment_triangle_intersect dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	logic [sti_pkg::THR_W-1:0] threshold;
	bary_res_t crossing_q[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 0;

	function automatic logic signed [CW+1:0] coord(logic [PW-1:0] p, int k);
		logic signed [CW-1:0] c;
		c = p[k*CW +: CW];
		return CW'(c) == c ? $signed({{2{c[CW-1]}}, c}) : 0;
	endfunction

	function automatic logic signed [127:0] dot(logic signed [127:0] x[3],
			logic signed [127:0] y[3]);
		return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
	endfunction

	function automatic void cross3(output logic signed [127:0] o[3],
			input logic signed [127:0] x[3], input logic signed [127:0] y[3]);
		o[0] = x[1] * y[2] - x[2] * y[1];
		o[1] = x[2] * y[0] - x[0] * y[2];
		o[2] = x[0] * y[1] - x[1] * y[0];
	endfunction

	function automatic logic [OW-1:0] weight(logic signed [127:0] x, logic signed [127:0] den);
		logic signed [127:0] q;
		q = (x <<< sti_pkg::FRAC_BITS) / den;
		return OW'(q);
	endfunction

	function automatic bary_res_t crossing(geom_t g);
		logic signed [127:0] d[3], u[3], v[3], w0[3], n[3], vd[3], uw[3];
		logic signed [127:0] den, num, sn, tn;
		bary_res_t r;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			d[k] = coord(g.p1, k) - coord(g.p0, k);
			u[k] = coord(g.vb, k) - coord(g.va, k);
			v[k] = coord(g.vc, k) - coord(g.va, k);
			w0[k] = coord(g.p0, k) - coord(g.va, k);
		end
		cross3(n, u, v);
		if (n[0] == 0 && n[1] == 0 && n[2] == 0)
			return r;
		den = dot(n, d);
		num = -dot(n, w0);
		cross3(vd, v, d);
		sn = dot(w0, vd);
		cross3(uw, u, w0);
		tn = dot(d, uw);
		if (den < 0) begin
			den = -den; num = -num; sn = -sn; tn = -tn;
		end
		if (den == 0 || den < threshold)
			return r;
		if (num < 0 || num > den || sn < 0 || tn < 0 || sn + tn > den)
			return r;
		r.hit = 1;
		r.s = weight(sn, den);
		r.t = weight(tn, den);
		r.w = OW'((1 << sti_pkg::FRAC_BITS) - r.s - r.t);
		return r;
	endfunction

	function automatic logic [PW-1:0] pt(int x, int y, int z);
		return {CW'(z), CW'(y), CW'(x)};
	endfunction

	function automatic logic [PW-1:0] rnd_pt(int span);
		int k;
		logic [PW-1:0] p;
		for (k = 0; k < 3; k++)
			p[k*CW +: CW] = CW'($urandom_range(2 * span) - span);
		return p;
	endfunction

	// mostly segments aimed through the triangle so hits are common
	function automatic geom_t rnd_geom();
		geom_t g;
		int span, sel;
		sel = $urandom_range(9);
		span = (sel < 2) ? 32767 : (sel < 6 ? 2000 : 60);
		g.va = rnd_pt(span);
		g.vb = rnd_pt(span);
		g.vc = rnd_pt(span);
		if (sel == 0) begin
			g.p0 = PW'({$urandom, $urandom});
			g.p1 = PW'({$urandom, $urandom});
		end else begin
			logic [PW-1:0] m;
			for (int k = 0; k < 3; k++)
				m[k*CW +: CW] = CW'((int'($signed(g.va[k*CW +: CW])) +
					int'($signed(g.vb[k*CW +: CW])) + int'($signed(g.vc[k*CW +: CW]))) / 3);
			g.p0 = m;
			g.p1 = m;
			for (int k = 0; k < 3; k++) begin
				g.p0[k*CW +: CW] = g.p0[k*CW +: CW] + CW'($urandom_range(2 * span) - span);
				g.p1[k*CW +: CW] = g.p1[k*CW +: CW] - CW'($urandom_range(2 * span) - span);
			end
		end
		return g;
	endfunction

	task automatic write_threshold(logic [sti_pkg::THR_W-1:0] value);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= sti_pkg::ADDR_W'(sti_pkg::REG_PARALLEL_THRESHOLD) << 2;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		threshold = value;
	endtask

	task automatic send(geom_t g, logic known, bary_res_t res);
		bary_res_t p;
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 0;
			@(posedge clk);
		end
		p = crossing(g);
		if (known && p != res) begin
			$error("directed row: expected %h, predictor %h", res, p);
			errors++;
		end
		crossing_q.push_back(p);
		in_valid <= 1;
		{seg_start, seg_end, vert_a, vert_b, vert_c} <= g;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (crossing_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 23);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (crossing_q.size() == 0) begin
				$error("unexpected transfer");
				errors++;
			end else begin
				bary_res_t e;
				e = crossing_q.pop_front();
				if (hit !== e.hit) begin
					$error("hit expected %0d actual %0d", e.hit, hit); errors++;
				end
				if (bary_s !== e.s) begin
					$error("bary_s expected %0d actual %0d", e.s, bary_s); errors++;
				end
				if (bary_t !== e.t) begin
					$error("bary_t expected %0d actual %0d", e.t, bary_t); errors++;
				end
				if (bary_w !== e.w) begin
					$error("bary_w expected %0d actual %0d", e.w, bary_w); errors++;
				end
			end
		end
	end

	localparam bary_res_t MISS = '0;
	localparam bary_res_t CENTER_HIT = '{1'b1, 17'd0, 17'd0, 17'd65536};

	vec_row_t rows[$];

	initial begin
		geom_t g;
		bary_res_t none;
		logic [sti_pkg::THR_W-1:0] thr_set[4];
		none = '0;
		threshold = sti_pkg::THR_RESET;
		// segment through vertex a, a tip hit
		rows.push_back('{'{pt(0, 0, -5), pt(0, 0, 5), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 1, CENTER_HIT});
		// degenerate triangle
		rows.push_back('{'{pt(0, 0, -5), pt(0, 0, 5), pt(0, 0, 0), pt(1, 1, 1),
			pt(2, 2, 2)}, 1, MISS});
		// zero length segment
		rows.push_back('{'{pt(1, 1, 0), pt(1, 1, 0), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 1, MISS});
		// parallel to plane
		rows.push_back('{'{pt(1, 1, 3), pt(5, 1, 3), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 1, MISS});
		// segment ends short of plane, touching at end, touching at start
		rows.push_back('{'{pt(1, 1, -5), pt(1, 1, -1), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 1, MISS});
		rows.push_back('{'{pt(1, 1, -5), pt(1, 1, 0), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 0, none});
		rows.push_back('{'{pt(1, 1, 0), pt(1, 1, 7), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 0, none});
		// outside, on edge, on hypotenuse, at vertex b and c
		rows.push_back('{'{pt(9, 9, -1), pt(9, 9, 1), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 1, MISS});
		rows.push_back('{'{pt(5, 0, -1), pt(5, 0, 1), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 0, none});
		rows.push_back('{'{pt(5, 5, -1), pt(5, 5, 1), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 0, none});
		rows.push_back('{'{pt(10, 0, 1), pt(10, 0, -1), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 0, none});
		rows.push_back('{'{pt(0, 10, 1), pt(0, 10, -1), pt(0, 0, 0), pt(10, 0, 0),
			pt(0, 10, 0)}, 0, none});
		rows.push_back('{'{pt(3, 4, 2), pt(3, 4, -9), pt(0, 0, 0), pt(7, 0, 0),
			pt(0, 13, 0)}, 0, none});
		// extreme coordinates
		rows.push_back('{'{pt(-32768, -32768, -32768), pt(32767, 32767, 32767),
			pt(-32768, 32767, 0), pt(32767, -32768, 0), pt(32767, 32767, -32768)}, 0, none});
		rows.push_back('{'{pt(-1, -1, -32768), pt(-1, -1, 32767), pt(-32768, -32768, 0),
			pt(32767, -32768, 0), pt(-32768, 32767, 0)}, 0, none});
		rows.push_back('{'{{PW{1'b1}}, '0, {PW{1'b1}}, pt(32767, 0, 0), pt(0, 32767, 0)},
			0, none});
		rows.push_back('{'{pt(0, 0, 32767), pt(0, 0, -32768), pt(-32768, -32768, 1),
			pt(32767, 0, 0), pt(0, 32767, -1)}, 0, none});

		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		foreach (rows[i])
			send(rows[i].g, rows[i].known, rows[i].res);
		drain();

		thr_set = '{20'd0, 20'hFFFFF, 20'd5000, 20'd1};
		foreach (thr_set[k]) begin
			write_threshold(thr_set[k]);
			calm = (k == 2);
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				g = rnd_geom();
				send(g, 0, none);
			end
			drain();
		end

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
